FILE: hdl/pse_pkg.sv
package pse_pkg;

    localparam int DATA_W = 32;

    // token kinds
    typedef logic [2:0] t_cmd;
    localparam t_cmd CMD_PUSH = 3'd0;
    localparam t_cmd CMD_ADD  = 3'd1;
    localparam t_cmd CMD_SUB  = 3'd2;
    localparam t_cmd CMD_MUL  = 3'd3;
    localparam t_cmd CMD_DIV  = 3'd4;
    localparam t_cmd CMD_REM  = 3'd5;

    // result status codes
    typedef logic [2:0] t_status;
    localparam t_status ST_OK       = 3'd0;
    localparam t_status ST_FEW      = 3'd1;
    localparam t_status ST_LEFTOVER = 3'd2;
    localparam t_status ST_OVERFLOW = 3'd3;
    localparam t_status ST_DIVZERO  = 3'd4;

    // divider runs one quotient bit per cycle
    localparam int DIV_CNT_W = 5;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = 5'd31;

    typedef enum logic [1:0] {
        ALU_IDLE,
        ALU_DIV,
        ALU_SIGN
    } t_alu_state;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_READ,
        SEQ_WAIT,
        SEQ_DONE
    } t_seq_state;

    // request from the sequencer to the arithmetic unit
    typedef struct packed {
        logic start;
        t_cmd op;
    } t_alu_req;

endpackage

FILE: hdl/pse_ram.sv
module pse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/pse_alu.sv
module pse_alu (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pse_pkg::t_alu_req            i_req,
    input  logic [pse_pkg::DATA_W-1:0]   i_lhs,
    input  logic [pse_pkg::DATA_W-1:0]   i_rhs,
    output logic                         o_done,
    output logic [pse_pkg::DATA_W-1:0]   o_result
);

    import pse_pkg::*;

    t_alu_state             r_state, n_state;
    logic                   r_done, n_done;
    logic [DIV_CNT_W-1:0]   r_cnt, n_cnt;
    logic [DATA_W-1:0]      r_result, n_result;
    logic [DATA_W-1:0]      r_quo, n_quo;
    logic [DATA_W-1:0]      r_rem, n_rem;
    logic [DATA_W-1:0]      r_div, n_div;
    t_cmd                   r_op, n_op;
    logic                   r_lneg, n_lneg;
    logic                   r_rneg, n_rneg;

    logic [DATA_W-1:0]      w_lmag;
    logic [DATA_W-1:0]      w_rmag;
    logic [DATA_W:0]        w_shift;
    logic [DATA_W:0]        w_diff;

    // operand magnitudes; the most negative value maps onto itself as unsigned
    assign w_lmag = i_lhs[DATA_W-1] ? (DATA_W'(0) - i_lhs) : i_lhs;
    assign w_rmag = i_rhs[DATA_W-1] ? (DATA_W'(0) - i_rhs) : i_rhs;

    // restoring divide step: shift in the next dividend bit, try a subtract
    assign w_shift = {r_rem, r_quo[DATA_W-1]};
    assign w_diff  = w_shift - {1'b0, r_div};

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ALU_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_cnt   <= n_cnt;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        r_quo    <= n_quo;
        r_rem    <= n_rem;
        r_div    <= n_div;
        r_op     <= n_op;
        r_lneg   <= n_lneg;
        r_rneg   <= n_rneg;
    end

    // next state and shared arithmetic
    always_comb begin
        n_state  = r_state;
        n_done   = 1'b0;
        n_cnt    = r_cnt;
        n_result = r_result;
        n_quo    = r_quo;
        n_rem    = r_rem;
        n_div    = r_div;
        n_op     = r_op;
        n_lneg   = r_lneg;
        n_rneg   = r_rneg;
        case (r_state)
            ALU_IDLE: begin
                if (i_req.start) begin
                    case (i_req.op)
                        CMD_ADD: begin
                            n_result = i_lhs + i_rhs;
                            n_done   = 1'b1;
                        end
                        CMD_SUB: begin
                            n_result = i_lhs - i_rhs;
                            n_done   = 1'b1;
                        end
                        CMD_MUL: begin
                            n_result = i_lhs * i_rhs;
                            n_done   = 1'b1;
                        end
                        CMD_DIV, CMD_REM: begin
                            n_quo   = w_lmag;
                            n_rem   = '0;
                            n_div   = w_rmag;
                            n_cnt   = '0;
                            n_op    = i_req.op;
                            n_lneg  = i_lhs[DATA_W-1];
                            n_rneg  = i_rhs[DATA_W-1];
                            n_state = ALU_DIV;
                        end
                        default: begin
                            n_result = '0;
                            n_done   = 1'b1;
                        end
                    endcase
                end
            end
            ALU_DIV: begin
                n_rem = w_diff[DATA_W] ? w_shift[DATA_W-1:0] : w_diff[DATA_W-1:0];
                n_quo = {r_quo[DATA_W-2:0], ~w_diff[DATA_W]};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = ALU_SIGN;
                end
            end
            ALU_SIGN: begin
                // quotient negative when signs differ, remainder follows the dividend
                if (r_op == CMD_DIV) begin
                    n_result = (r_lneg ^ r_rneg) ? (DATA_W'(0) - r_quo) : r_quo;
                end else begin
                    n_result = r_lneg ? (DATA_W'(0) - r_rem) : r_rem;
                end
                n_done  = 1'b1;
                n_state = ALU_IDLE;
            end
            default: begin
                n_state = ALU_IDLE;
            end
        endcase
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

FILE: hdl/postfix_stack_evaluator_top.sv
// channel   dir  tdata                  tuser          tlast
// s_axis    in   operand [31:0]         cmd [2:0]      last_token
// m_axis    out  result_value [31:0]    status [2:0]   -
//
// a push, an ignored code or a token that raises an error is taken in the idle state;
// add, subtract and multiply pass through stack read, unit and write back;
// divide and remainder also wait on the radix-2 divider in the shared unit.
// the last token of an expression then goes to a state that loads the output register,
// and waits there while the previous result is still not taken.
// synchronous active-low reset empties the stack and drops any pending result.
module postfix_stack_evaluator_top #(
    parameter int STACK_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic signed [31:0] s_axis_tdata,   // operand
    input  logic [2:0]         s_axis_tuser,   // cmd
    input  logic               s_axis_tlast,   // last_token
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic signed [31:0] m_axis_tdata,   // result_value
    output logic [2:0]         m_axis_tuser    // status
);

    import pse_pkg::*;

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);

    t_seq_state         r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    t_status            r_err, n_err;
    logic [DATA_W-1:0]  r_tos, n_tos;
    t_cmd               r_cmd, n_cmd;
    logic               r_last, n_last;
    logic               r_out_valid, n_out_valid;
    logic [DATA_W-1:0]  r_out_data, n_out_data;
    t_status            r_out_status, n_out_status;

    logic               w_accept;
    logic               w_ram_we;
    logic               w_ram_re;
    logic [ADDR_W-1:0]  w_ram_waddr;
    logic [ADDR_W-1:0]  w_ram_raddr;
    logic [DATA_W-1:0]  w_ram_rdata;
    t_alu_req           w_alu_req;
    logic               w_alu_done;
    logic [DATA_W-1:0]  w_alu_result;

    // entries below the top live in the memory, the top in r_tos
    pse_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (r_tos),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    pse_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_alu_req),
        .i_lhs    (w_ram_rdata),
        .i_rhs    (r_tos),
        .o_done   (w_alu_done),
        .o_result (w_alu_result)
    );

    assign s_axis_tready = (r_state == SEQ_IDLE);
    assign w_accept      = s_axis_tvalid & s_axis_tready;
    assign w_ram_waddr   = ADDR_W'(r_count - 1'b1);
    assign w_ram_raddr   = ADDR_W'(r_count - CNT_W'(2));

    // state register and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= SEQ_IDLE;
            r_count     <= '0;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_tos        <= n_tos;
        r_cmd        <= n_cmd;
        r_last       <= n_last;
        r_out_data   <= n_out_data;
        r_out_status <= n_out_status;
    end

    // token sequencer
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_err         = r_err;
        n_tos         = r_tos;
        n_cmd         = r_cmd;
        n_last        = r_last;
        n_out_valid   = r_out_valid & ~m_axis_tready;
        n_out_data    = r_out_data;
        n_out_status  = r_out_status;
        w_ram_we      = 1'b0;
        w_ram_re      = 1'b0;
        w_alu_req.start = 1'b0;
        w_alu_req.op    = r_cmd;
        case (r_state)
            SEQ_IDLE: begin
                if (w_accept) begin
                    n_cmd   = s_axis_tuser;
                    n_last  = s_axis_tlast;
                    n_state = s_axis_tlast ? SEQ_DONE : SEQ_IDLE;
                    // after the first error the rest of the expression is skipped
                    if (r_err == ST_OK) begin
                        if (s_axis_tuser == CMD_PUSH) begin
                            if (r_count >= CNT_W'(STACK_DEPTH)) begin
                                n_err = ST_OVERFLOW;
                            end else begin
                                w_ram_we = (r_count != '0);
                                n_tos    = s_axis_tdata;
                                n_count  = r_count + 1'b1;
                            end
                        end else if (s_axis_tuser <= CMD_REM) begin
                            if (r_count < CNT_W'(2)) begin
                                n_err = ST_FEW;
                            end else if ((s_axis_tuser == CMD_DIV ||
                                          s_axis_tuser == CMD_REM) && r_tos == '0) begin
                                n_err = ST_DIVZERO;
                            end else begin
                                w_ram_re = 1'b1;
                                n_state  = SEQ_READ;
                            end
                        end
                    end
                end
            end
            SEQ_READ: begin
                // left operand is now out of the memory
                w_alu_req.start = 1'b1;
                n_state         = SEQ_WAIT;
            end
            SEQ_WAIT: begin
                if (w_alu_done) begin
                    n_tos   = w_alu_result;
                    n_count = r_count - 1'b1;
                    n_state = r_last ? SEQ_DONE : SEQ_IDLE;
                end
            end
            SEQ_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = '0;
                    if (r_err != ST_OK) begin
                        n_out_status = r_err;
                    end else if (r_count == '0) begin
                        n_out_status = ST_FEW;
                    end else if (r_count > CNT_W'(1)) begin
                        n_out_status = ST_LEFTOVER;
                    end else begin
                        n_out_status = ST_OK;
                        n_out_data   = r_tos;
                    end
                    n_count = '0;
                    n_err   = ST_OK;
                    n_state = SEQ_IDLE;
                end
            end
            default: begin
                n_state = SEQ_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_status;

endmodule

FILE: hdl/pse_checker.sv
module pse_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [31:0] s_axis_tdata,
    input logic [2:0]  s_axis_tuser,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);

    import pse_pkg::*;

    // a stalled result beat stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // error results carry a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata == '0)
        else $error("nonzero value with error status");

    // the input is never ready in the cycle after the last token of an expression
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("ready right after a last token");

    // reset drops any pending result
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind postfix_stack_evaluator_top pse_checker u_pse_checker (.*);

FILE: dv/postfix_stack_evaluator_top_tb.sv
`timescale 1ns / 100ps

module postfix_stack_evaluator_top_tb;

    import pse_pkg::*;

    localparam int STACK_DEPTH = 16;
    localparam int RANDOM_TOKENS = 2000;
    localparam int CYCLE_LIMIT = 800000;
    localparam int MAX_IDLE = 12;

    // token codes with no operation behind them
    localparam t_cmd CMD_SPARE_LO = 3'd6;
    localparam t_cmd CMD_SPARE_HI = 3'd7;

    typedef struct {
        logic [31:0] value;
        t_status     status;
    } t_outcome;

    // one line of the directed script, rep repeats the token, last only on the final copy
    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] opnd;
        logic        last;
        logic [4:0]  rep;
        logic        typed;
        logic [31:0] value;
        t_status     status;
    } t_script_row;

    localparam int SCRIPT_LEN = 24;
    localparam t_script_row SCRIPT [SCRIPT_LEN] = '{
        '{CMD_PUSH,     32'd7,         1'b1, 5'd1,  1'b1, 32'd7,         ST_OK},
        '{CMD_ADD,      32'd0,         1'b1, 5'd1,  1'b1, 32'd0,         ST_FEW},
        '{CMD_PUSH,     32'h7fffffff,  1'b0, 5'd1,  1'b0, 32'd0,         ST_OK},
        '{CMD_PUSH,     32'd1,         1'b0, 5'd1,  1'b0, 32'd0,         ST_OK},
        '{CMD_ADD,      32'd0,         1'b1, 5'd1,  1'b1, 32'h80000000,  ST_OK},
        '{CMD_PUSH,     32'h80000000,  1'b0, 5'd1,  1'b0, 32'd0,         ST_OK},
        '{CMD_PUSH,     32'hffffffff,  1'b0, 5'd1,  1'b0, 32'd0,         ST_OK},
        '{CMD_DIV,      32'd0,         1'b1, 5'd1,  1'b1, 32'h80000000,  ST_OK},
        '{CMD_PUSH,     32'h80000000,  1'b0, 5'd1,  1'b0, 32'd0,         ST_OK},
        '{CMD_PUSH,     32'hffffffff,  1'b0, 5'd1,  1'b0, 32'd0,         ST_OK},
        '{CMD_REM,      32'd0,         1'b1, 5'd1,  1'b1, 32'd0,         ST_OK},
        '{CMD_PUSH,     32'hfffffff9,  1'b0, 5'd1,  1'b0, 32'd0,         ST_OK},
        '{CMD_PUSH,     32'd2,         1'b0, 5'd1,  1'b0, 32'd0,         ST_OK},
        '{CMD_REM,      32'd0,         1'b0, 5'd1,  1'b0, 32'd0,         ST_OK},
        '{CMD_PUSH,     32'd3,         1'b0, 5'd1,  1'b0, 32'd0,         ST_OK},
        '{CMD_SUB,      32'h12345678,  1'b0, 5'd1,  1'b0, 32'd0,         ST_OK},
        '{CMD_PUSH,     32'h00010001,  1'b0, 5'd1,  1'b0, 32'd0,         ST_OK},
        '{CMD_MUL,      32'hffffffff,  1'b1, 5'd1,  1'b0, 32'd0,         ST_OK},
        '{CMD_PUSH,     32'd6,         1'b1, 5'd2,  1'b1, 32'd0,         ST_LEFTOVER},
        '{CMD_PUSH,     32'd0,         1'b0, 5'd2,  1'b0, 32'd0,         ST_OK},
        '{CMD_DIV,      32'd0,         1'b1, 5'd1,  1'b1, 32'd0,         ST_DIVZERO},
        '{CMD_PUSH,     32'h55555555,  1'b1, 5'd17, 1'b1, 32'd0,         ST_OVERFLOW},
        '{CMD_SPARE_LO, 32'd0,         1'b1, 5'd1,  1'b1, 32'd0,         ST_FEW},
        '{CMD_SPARE_HI, 32'haaaaaaaa,  1'b0, 5'd1,  1'b0, 32'd0,         ST_OK}
    };

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic signed [31:0] s_axis_tdata = '0;   // operand
    logic [2:0]         s_axis_tuser = '0;   // cmd
    logic               s_axis_tlast = 1'b0; // last_token
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic signed [31:0] m_axis_tdata;        // result_value
    logic [2:0]         m_axis_tuser;        // status

    // predictor state
    logic [31:0] eval_stack [STACK_DEPTH];
    int          eval_depth = 0;
    t_status     eval_error = ST_OK;

    t_outcome results_due [$];
    int       token_cnt = 0;
    int       mismatch_cnt = 0;
    int       cycle_cnt = 0;
    bit       send_steady = 1'b0;
    bit       recv_steady = 1'b0;

    postfix_stack_evaluator_top #(
        .STACK_DEPTH(STACK_DEPTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // apply one token to the predicted stack, give the result when the expression ends
    task automatic eval_postfix_token(input t_cmd cmd, input logic [31:0] opnd,
                                      input logic last, output bit emits,
                                      output t_outcome res);
        logic [31:0] lhs;
        logic [31:0] rhs;
        logic [31:0] lmag;
        logic [31:0] rmag;
        logic [31:0] acc;
        emits = 1'b0;
        res.value = '0;
        res.status = ST_OK;
        if (eval_error == ST_OK) begin
            if (cmd == CMD_PUSH) begin
                if (eval_depth >= STACK_DEPTH) begin
                    eval_error = ST_OVERFLOW;
                end else begin
                    eval_stack[eval_depth] = opnd;
                    eval_depth++;
                end
            end else if (cmd <= CMD_REM) begin
                if (eval_depth < 2) begin
                    eval_error = ST_FEW;
                end else begin
                    rhs = eval_stack[eval_depth-1];
                    lhs = eval_stack[eval_depth-2];
                    if ((cmd == CMD_DIV || cmd == CMD_REM) && rhs == '0) begin
                        eval_error = ST_DIVZERO;
                    end else begin
                        lmag = lhs[31] ? -lhs : lhs;
                        rmag = rhs[31] ? -rhs : rhs;
                        case (cmd)
                            CMD_ADD: acc = lhs + rhs;
                            CMD_SUB: acc = lhs - rhs;
                            CMD_MUL: acc = lhs * rhs;
                            CMD_DIV: begin
                                acc = lmag / rmag;
                                if (lhs[31] ^ rhs[31])
                                    acc = -acc;
                            end
                            default: begin
                                // remainder follows the sign of the left operand
                                acc = lmag % rmag;
                                if (lhs[31])
                                    acc = -acc;
                            end
                        endcase
                        eval_depth--;
                        eval_stack[eval_depth-1] = acc;
                    end
                end
            end
        end
        if (last) begin
            emits = 1'b1;
            if (eval_error != ST_OK)
                res.status = eval_error;
            else if (eval_depth == 0)
                res.status = ST_FEW;
            else if (eval_depth > 1)
                res.status = ST_LEFTOVER;
            else
                res.value = eval_stack[0];
            eval_depth = 0;
            eval_error = ST_OK;
        end
    endtask

    // send one token beat after a random gap, then queue what it produces
    task automatic drive_token(input t_cmd cmd, input logic [31:0] opnd, input logic last,
                               input bit typed = 1'b0, input logic [31:0] tv = '0,
                               input t_status ts = ST_OK);
        int       gap;
        bit       emits;
        t_outcome res;
        gap = send_steady ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= opnd;
        s_axis_tuser  <= cmd;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        eval_postfix_token(cmd, opnd, last, emits, res);
        if (emits) begin
            if (typed) begin
                res.value = tv;
                res.status = ts;
            end
            results_due.push_back(res);
        end
        if (cmd <= CMD_REM)
            token_cnt++;
        if ($urandom_range(0, 49) == 0)
            send_steady = !send_steady;
    endtask

    task automatic wait_results_drained();
        while (results_due.size() != 0) @(posedge i_clk);
    endtask

    // operand mix: full range, small values around zero, extremes
    function automatic logic [31:0] pick_operand();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return $urandom;
        else if (roll < 80)
            return $urandom_range(0, 20) - 10;
        case ($urandom_range(0, 4))
            0: return 32'h80000000;
            1: return 32'h7fffffff;
            2: return 32'hffffffff;
            3: return 32'd1;
            default: return 32'd0;
        endcase
    endfunction

    // stimulus
    initial begin
        int   roll;
        int   pushes;
        int   depth;
        int   len;
        bit   drained_mid;
        t_cmd op;
        drained_mid = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed script
        foreach (SCRIPT[i]) begin
            for (int r = 0; r < SCRIPT[i].rep; r++) begin
                drive_token(SCRIPT[i].cmd, SCRIPT[i].opnd,
                            SCRIPT[i].last && (r == SCRIPT[i].rep - 1),
                            SCRIPT[i].typed, SCRIPT[i].value, SCRIPT[i].status);
            end
        end
        s_axis_tvalid <= 1'b0;
        token_cnt = 0;
        wait_results_drained();
        @(posedge i_clk);

        // random expressions
        while (token_cnt < RANDOM_TOKENS) begin
            if (!drained_mid && token_cnt >= RANDOM_TOKENS / 2) begin
                s_axis_tvalid <= 1'b0;
                wait_results_drained();
                drained_mid = 1'b1;
            end
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                // well-formed expression with operators interleaved
                pushes = $urandom_range(1, 8);
                depth = 0;
                while (pushes > 0 || depth > 1) begin
                    if (depth >= 2 && (pushes == 0 || $urandom_range(0, 1) == 1)) begin
                        op = t_cmd'($urandom_range(CMD_ADD, CMD_REM));
                        drive_token(op, $urandom, pushes == 0 && depth == 2);
                        depth--;
                    end else begin
                        drive_token(CMD_PUSH, pick_operand(), pushes == 1 && depth == 0);
                        pushes--;
                        depth++;
                    end
                end
            end else if (roll < 80) begin
                // deep stack, past full on some
                len = $urandom_range(13, 18);
                for (int k = 0; k < len; k++)
                    drive_token(CMD_PUSH, pick_operand(), 1'b0);
                for (int k = 1; k < len; k++) begin
                    op = t_cmd'($urandom_range(CMD_ADD, CMD_REM));
                    drive_token(op, $urandom, k == len - 1);
                end
            end else begin
                // noise: any code, stray ends
                len = $urandom_range(1, 6);
                for (int k = 0; k < len; k++) begin
                    op = t_cmd'($urandom_range(CMD_PUSH, CMD_SPARE_HI));
                    drive_token(op, pick_operand(),
                                (k == len - 1) || ($urandom_range(0, 3) == 0));
                end
            end
        end
        s_axis_tvalid <= 1'b0;

        wait_results_drained();
        repeat (100) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // result side: random stalls, compare each beat with the oldest expectation
    initial begin
        t_outcome want;
        int       gap;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            gap = recv_steady ? 0 : $urandom_range(0, MAX_IDLE);
            if (gap != 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
            if (results_due.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result beat: value %h status %0d",
                             m_axis_tdata, m_axis_tuser);
            end else begin
                want = results_due.pop_front();
                if (m_axis_tdata !== want.value || m_axis_tuser !== want.status) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("result mismatch: expected %h/%0d, got %h/%0d",
                                 want.value, want.status, m_axis_tdata, m_axis_tuser);
                end
            end
            if ($urandom_range(0, 19) == 0)
                recv_steady = !recv_steady;
        end
    end

endmodule
